// ----- hdl/assert_macros.svh -----
// Assertion helpers. Both expect clk_i and rst_ni in the scope of the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define FLG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("flanger check failed");
// Condition must never be seen on a clock edge outside reset.
`define FLG_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("flanger forbidden condition seen");
`else
`define FLG_ASSERT(lbl, prop)
`define FLG_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/flg_pkg.sv -----
package flg_pkg;

  // Delay line
  localparam int BufferDepth = 512;
  localparam int PtrW        = $clog2(BufferDepth);

  // Sample format, Q1.15
  localparam int SampleW   = 16;
  localparam int GainFracW = 15;
  localparam int GainRound = 2 ** (GainFracW - 1);

  // LFO and sweep
  localparam int PhaseW      = 32;
  localparam int SineDepth   = 256;
  localparam int SineAw      = $clog2(SineDepth);
  localparam int SineIdxW    = SineAw + 1;
  localparam int SineEntries = SineDepth + 1;
  localparam int SineValW    = 15;
  localparam int LfoAw       = SineAw + 2;
  localparam int QuarterTurn = 2 ** SineAw;
  localparam int LfoW        = 16;
  localparam int LfoMid      = 2 ** (LfoW - 1);
  localparam int MaxSweep    = 220;
  localparam int SweepW      = $clog2(MaxSweep + 1);
  localparam int LfoScW      = LfoW + SweepW;
  localparam int DepthW      = 16;
  localparam int SweepProdW  = LfoScW + DepthW;
  localparam int SweepShift  = 24;
  localparam int FracW       = 8;
  localparam int DelayW      = SweepProdW - SweepShift;
  localparam int InterpRound = 2 ** (FracW - 1);

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int LfoIncW  = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLfoIncrement = 3'd0,
    CfgSweepDepth   = 3'd1,
    CfgFeedbackGain = 3'd2,
    CfgMixLevel     = 3'd3,
    CfgStereoMode   = 3'd4
  } cfg_index_e;

  localparam logic [LfoIncW-1:0]        LfoIncReset = LfoIncW'(48695);
  localparam logic [DepthW-1:0]         DepthReset  = DepthW'(32768);
  localparam logic signed [SampleW-1:0] FbReset     = '0;
  localparam logic [SampleW-1:0]        MixReset    = SampleW'(16384);
  localparam logic signed [SampleW-1:0] FbLimitHi   = SampleW'(31130);
  localparam logic signed [SampleW-1:0] FbLimitLo   = SampleW'(-31130);
  localparam logic [SampleW-1:0]        MixFull     = SampleW'(32768);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSweep,
    StAddr,
    StInterp,
    StProduct,
    StWrite
  } state_e;

  typedef struct packed {
    logic load_lfo;
    logic load_sweep;
    logic load_wet;
    logic load_prod;
    logic commit;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [DepthW-1:0]         depth;
    logic signed [SampleW-1:0] fb;
    logic [SampleW-1:0]        mix;
  } lane_cfg_t;

  // Quarter-wave sine table, built at elaboration from an odd degree-9 polynomial
  // evaluated in Q30, then rounded to Q15.
  typedef logic [SineValW-1:0] sine_rom_t [SineEntries];

  localparam longint Q30     = 64'sd1073741824;
  localparam longint SineMax = 2 ** SineValW - 1;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    t;
    longint    t2;
    longint    p;
    longint    v;
    int        k;
    for (k = 0; k < SineEntries; k++) begin
      // k is never negative, so the shift equals the truncating division by the depth
      t  = (longint'(k) * Q30) >>> SineAw;
      t2 = (t * t) / Q30;
      p  = 64'sd172271;
      p  = -64'sd5026995 + (p * t2) / Q30;
      p  = 64'sd85569306 + (p * t2) / Q30;
      p  = -64'sd693598668 + (p * t2) / Q30;
      p  = 64'sd1686629713 + (p * t2) / Q30;
      v  = (p * t) / Q30;
      v  = (v + 64'sd16384) / 64'sd32768;
      if (v < 0) v = 0;
      if (v > SineMax) v = SineMax;
      rom[k] = v[SineValW-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

// ----- hdl/stereo_flanger_core.sv -----
// Stereo flanger, one stereo frame per request. After reset the core first zeroes both
// 512-entry delay lines, one entry per cycle, and takes no frame until both are clear
// (configuration writes are taken at any time). After the idle cycle that takes the
// request, a frame steps through the sweep, address, interpolation, product and
// write-back states. Write-back loads the result and returns the core to idle, ready
// for the next request. The steps follow the read-modify-write pass over the delay-line
// RAM (registered read) and the registered multiplies behind it: sweep depth, tap
// interpolation, then feedback and dry/wet mix. The result register holds a finished
// frame while the next one is already accepted; a frame only stalls in its last step
// when the previous result has not yet been taken. Right runs 90 degrees ahead of
// left on the same LFO; in mono mode the right sample passes through untouched and
// the right line is not written.
`include "assert_macros.svh"

module stereo_flanger_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // frame input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [flg_pkg::SampleW-1:0]  left_in_i,
  input  logic signed [flg_pkg::SampleW-1:0]  right_in_i,
  // frame output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [flg_pkg::SampleW-1:0]  left_out_o,
  output logic signed [flg_pkg::SampleW-1:0]  right_out_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [flg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [flg_pkg::CfgDataW-1:0]        cfg_data_i
);

  // Sequencer state
  flg_pkg::state_e state_q, state_d;

  // Frame state: write pointer doubles as the clear counter after reset
  logic [flg_pkg::PtrW-1:0]   wp_q, wp_d;
  logic [flg_pkg::PhaseW-1:0] phase_q, phase_d;

  // Configuration registers, feedback and mix kept already clamped
  logic [flg_pkg::LfoIncW-1:0]        lfo_inc_q, lfo_inc_d;
  logic [flg_pkg::DepthW-1:0]         depth_q, depth_d;
  logic signed [flg_pkg::SampleW-1:0] fb_q, fb_d;
  logic [flg_pkg::SampleW-1:0]        mix_q, mix_d;
  logic                               stereo_q, stereo_d;

  // Dry samples of the frame in flight and the result register
  logic signed [flg_pkg::SampleW-1:0] dry_l_q, dry_r_q;
  logic signed [flg_pkg::SampleW-1:0] left_out_q, right_out_q;
  logic                               out_valid_q, out_valid_d;

  flg_pkg::lane_ctrl_t ctrl, ctrl_left, ctrl_right;
  flg_pkg::lane_cfg_t  lane_cfg;
  logic                in_ready;
  logic                out_free;
  logic                clr_last;
  logic                accept;
  logic [flg_pkg::PtrW-1:0]  lane_ptr;
  logic [flg_pkg::LfoAw-1:0] lfo_addr_l, lfo_addr_r;
  logic signed [flg_pkg::SampleW-1:0] res_l, res_r;
  logic signed [flg_pkg::SampleW-1:0] fb_wr;
  logic [flg_pkg::SampleW-1:0]        mix_wr;

  assign out_free = !out_valid_q || out_ready_i;
  assign clr_last = (wp_q == flg_pkg::PtrW'(flg_pkg::BufferDepth - 1));
  assign accept   = in_valid_i && in_ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flg_pkg::StClear:   if (clr_last) state_d = flg_pkg::StIdle;
      flg_pkg::StIdle:    if (in_valid_i) state_d = flg_pkg::StSweep;
      flg_pkg::StSweep:   state_d = flg_pkg::StAddr;
      flg_pkg::StAddr:    state_d = flg_pkg::StInterp;
      flg_pkg::StInterp:  state_d = flg_pkg::StProduct;
      flg_pkg::StProduct: state_d = flg_pkg::StWrite;
      flg_pkg::StWrite:   if (out_free) state_d = flg_pkg::StIdle;
      default:            state_d = flg_pkg::StClear;
    endcase
  end

  // Sequencer outputs. The LFO lookup runs in every idle cycle so its product is
  // ready on the edge that takes the request.
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state_q)
      flg_pkg::StClear:   ctrl.clear = 1'b1;
      flg_pkg::StIdle: begin
        in_ready      = 1'b1;
        ctrl.load_lfo = 1'b1;
      end
      flg_pkg::StSweep:   ctrl.load_sweep = 1'b1;
      flg_pkg::StAddr: begin
      end
      flg_pkg::StInterp:  ctrl.load_wet = 1'b1;
      flg_pkg::StProduct: ctrl.load_prod = 1'b1;
      flg_pkg::StWrite:   ctrl.commit = out_free;
      default: begin
      end
    endcase
  end

  // Mono mode: keep the right line frozen
  always_comb begin
    ctrl_left         = ctrl;
    ctrl_right        = ctrl;
    ctrl_right.commit = ctrl.commit && stereo_q;
  end

  // Advance phase and pointer once per committed frame; sweep the pointer while clearing
  always_comb begin
    wp_d    = wp_q;
    phase_d = phase_q;
    if (ctrl.clear || ctrl.commit) begin
      wp_d = wp_q + flg_pkg::PtrW'(1);
    end
    if (ctrl.commit) begin
      phase_d = phase_q + flg_pkg::PhaseW'(lfo_inc_q);
    end
  end

  // Result slot: fill on commit, drop when the request is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration decode with clamping of feedback and mix
  always_comb begin
    fb_wr = $signed(cfg_data_i[flg_pkg::SampleW-1:0]);
    if (fb_wr > flg_pkg::FbLimitHi) begin
      fb_wr = flg_pkg::FbLimitHi;
    end else if (fb_wr < flg_pkg::FbLimitLo) begin
      fb_wr = flg_pkg::FbLimitLo;
    end
    mix_wr = cfg_data_i[flg_pkg::SampleW-1:0];
    if (mix_wr > flg_pkg::MixFull) begin
      mix_wr = flg_pkg::MixFull;
    end
  end

  always_comb begin
    lfo_inc_d = lfo_inc_q;
    depth_d   = depth_q;
    fb_d      = fb_q;
    mix_d     = mix_q;
    stereo_d  = stereo_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        flg_pkg::CfgLfoIncrement: lfo_inc_d = cfg_data_i[flg_pkg::LfoIncW-1:0];
        flg_pkg::CfgSweepDepth:   depth_d   = cfg_data_i[flg_pkg::DepthW-1:0];
        flg_pkg::CfgFeedbackGain: fb_d      = fb_wr;
        flg_pkg::CfgMixLevel:     mix_d     = mix_wr;
        flg_pkg::CfgStereoMode:   stereo_d  = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flg_pkg::StClear;
      wp_q        <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      lfo_inc_q   <= flg_pkg::LfoIncReset;
      depth_q     <= flg_pkg::DepthReset;
      fb_q        <= flg_pkg::FbReset;
      mix_q       <= flg_pkg::MixReset;
      stereo_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      lfo_inc_q   <= lfo_inc_d;
      depth_q     <= depth_d;
      fb_q        <= fb_d;
      mix_q       <= mix_d;
      stereo_q    <= stereo_d;
    end
  end

  // Payload: hold dry samples for the frame, load results on commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dry_l_q <= left_in_i;
      dry_r_q <= right_in_i;
    end
    if (ctrl.commit) begin
      left_out_q  <= res_l;
      right_out_q <= stereo_q ? res_r : dry_r_q;
    end
  end

  // Lanes: right channel reads the phase a quarter turn ahead
  assign lfo_addr_l = phase_q[flg_pkg::PhaseW-1 -: flg_pkg::LfoAw];
  assign lfo_addr_r = lfo_addr_l + flg_pkg::LfoAw'(flg_pkg::QuarterTurn);
  assign lane_ptr   = wp_q;

  always_comb begin
    lane_cfg.depth = depth_q;
    lane_cfg.fb    = fb_q;
    lane_cfg.mix   = mix_q;
  end

  flg_lane u_lane_left (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_left),
    .cfg_i      (lane_cfg),
    .lfo_addr_i (lfo_addr_l),
    .ptr_i      (lane_ptr),
    .dry_i      (dry_l_q),
    .result_o   (res_l)
  );

  flg_lane u_lane_right (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl_right),
    .cfg_i      (lane_cfg),
    .lfo_addr_i (lfo_addr_r),
    .ptr_i      (lane_ptr),
    .dry_i      (dry_r_q),
    .result_o   (res_r)
  );

  assign in_ready_o  = in_ready;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  // A new result only ever comes from the write-back step
  `FLG_ASSERT(a_result_from_write, $rose(out_valid_q) |-> $past(state_q == flg_pkg::StWrite))
  // Never overwrite a result that has not been taken
  `FLG_NEVER(a_slot_overwrite, ctrl.commit && out_valid_q && !out_ready_i)
  // The pointer moves only while clearing or on write-back
  `FLG_ASSERT(a_ptr_moves, !$stable(wp_q) |-> $past(state_q == flg_pkg::StWrite || state_q == flg_pkg::StClear))

endmodule

// ----- hdl/flg_line_ram.sv -----
module flg_line_ram (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [flg_pkg::PtrW-1:0]            waddr_i,
  input  logic [flg_pkg::SampleW-1:0]         wdata_i,
  input  logic [flg_pkg::PtrW-1:0]            raddr_a_i,
  input  logic [flg_pkg::PtrW-1:0]            raddr_b_i,
  output logic [flg_pkg::SampleW-1:0]         rdata_a_o,
  output logic [flg_pkg::SampleW-1:0]         rdata_b_o
);

  logic [flg_pkg::SampleW-1:0] mem_q [flg_pkg::BufferDepth];
  logic [flg_pkg::SampleW-1:0] rdata_a_q;
  logic [flg_pkg::SampleW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hdl/flg_lane.sv -----
module flg_lane (
  input  logic                                clk_i,
  input  flg_pkg::lane_ctrl_t                 ctrl_i,
  input  flg_pkg::lane_cfg_t                  cfg_i,
  input  logic [flg_pkg::LfoAw-1:0]           lfo_addr_i,
  input  logic [flg_pkg::PtrW-1:0]            ptr_i,
  input  logic signed [flg_pkg::SampleW-1:0]  dry_i,
  output logic signed [flg_pkg::SampleW-1:0]  result_o
);

  localparam int InterpProdW = flg_pkg::SampleW + flg_pkg::FracW + 2;
  localparam int InterpW     = flg_pkg::SampleW + flg_pkg::FracW + 3;
  localparam int FbProdW     = 2 * flg_pkg::SampleW;
  localparam int FbSumW      = FbProdW + 1;
  localparam int DiffW       = flg_pkg::SampleW + 1;
  localparam int MixProdW    = 2 * DiffW;
  localparam int SumW        = MixProdW + 2;
  localparam logic signed [SumW-1:0] SatHi = SumW'(2 ** (flg_pkg::SampleW - 1) - 1);
  localparam logic signed [SumW-1:0] SatLo = SumW'(-(2 ** (flg_pkg::SampleW - 1)));

  function automatic logic signed [flg_pkg::SampleW-1:0] sat_sample(
    input logic signed [SumW-1:0] v
  );
    logic signed [flg_pkg::SampleW-1:0] r;
    if (v > SatHi) begin
      r = SatHi[flg_pkg::SampleW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[flg_pkg::SampleW-1:0];
    end else begin
      r = v[flg_pkg::SampleW-1:0];
    end
    return r;
  endfunction

  // LFO lookup
  logic [1:0]                      quad;
  logic [flg_pkg::SineAw-1:0]      pos;
  logic [flg_pkg::SineIdxW-1:0]    rom_idx;
  logic [flg_pkg::SineValW-1:0]    rom_val;
  logic [flg_pkg::LfoW-1:0]        lfo;
  logic [flg_pkg::LfoScW-1:0]      lfo_sc_d, lfo_sc_q;

  always_comb begin
    quad    = lfo_addr_i[flg_pkg::LfoAw-1 -: 2];
    pos     = lfo_addr_i[flg_pkg::SineAw-1:0];
    rom_idx = quad[0] ? (flg_pkg::SineIdxW'(flg_pkg::SineDepth) - {1'b0, pos})
                      : {1'b0, pos};
    rom_val = flg_pkg::SineRom[rom_idx];
    lfo     = quad[1] ? (flg_pkg::LfoW'(flg_pkg::LfoMid) - flg_pkg::LfoW'(rom_val))
                      : (flg_pkg::LfoW'(flg_pkg::LfoMid) + flg_pkg::LfoW'(rom_val));
    lfo_sc_d = flg_pkg::LfoScW'(lfo) * flg_pkg::LfoScW'(flg_pkg::MaxSweep);
  end

  // Sweep product and tap addresses
  logic [flg_pkg::SweepProdW-1:0]  sweep_prod;
  logic [flg_pkg::DelayW-1:0]      delay_q;
  logic [flg_pkg::PtrW-1:0]        dly_int;
  logic [flg_pkg::PtrW-1:0]        addr_newer;
  logic [flg_pkg::PtrW-1:0]        addr_older;
  logic [flg_pkg::FracW-1:0]       frac;

  always_comb begin
    sweep_prod = flg_pkg::SweepProdW'(lfo_sc_q) * flg_pkg::SweepProdW'(cfg_i.depth);
    dly_int    = flg_pkg::PtrW'(delay_q[flg_pkg::DelayW-1:flg_pkg::FracW])
               + flg_pkg::PtrW'(1);
    addr_newer = ptr_i - dly_int;
    addr_older = addr_newer - flg_pkg::PtrW'(1);
    frac       = delay_q[flg_pkg::FracW-1:0];
  end

  // Delay-line memory
  logic [flg_pkg::SampleW-1:0]        rd_newer, rd_older;
  logic                               mem_we;
  logic [flg_pkg::SampleW-1:0]        mem_wdata;
  logic signed [flg_pkg::SampleW-1:0] store_val;

  assign mem_we    = ctrl_i.clear | ctrl_i.commit;
  assign mem_wdata = ctrl_i.clear ? '0 : store_val;

  flg_line_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (ptr_i),
    .wdata_i   (mem_wdata),
    .raddr_a_i (addr_newer),
    .raddr_b_i (addr_older),
    .rdata_a_o (rd_newer),
    .rdata_b_o (rd_older)
  );

  // Linear interpolation between the two taps
  logic signed [flg_pkg::SampleW-1:0] tap_new, tap_old;
  logic signed [DiffW-1:0]            tap_diff;
  logic signed [InterpProdW-1:0]      interp_prod;
  logic signed [InterpW-1:0]          interp_sum;
  logic signed [flg_pkg::SampleW-1:0] wet_d, wet_q;

  always_comb begin
    tap_new     = $signed(rd_newer);
    tap_old     = $signed(rd_older);
    tap_diff    = DiffW'(tap_old) - DiffW'(tap_new);
    interp_prod = tap_diff * $signed({1'b0, frac});
    interp_sum  = (InterpW'(tap_new) <<< flg_pkg::FracW) + InterpW'(interp_prod)
                + InterpW'(flg_pkg::InterpRound);
    wet_d       = interp_sum[flg_pkg::FracW +: flg_pkg::SampleW];
  end

  // Feedback and mix products
  logic signed [FbProdW-1:0]  fb_prod_d, fb_prod_q;
  logic signed [DiffW-1:0]    mix_diff;
  logic signed [MixProdW-1:0] mix_prod_d, mix_prod_q;

  always_comb begin
    fb_prod_d  = wet_q * cfg_i.fb;
    mix_diff   = DiffW'(wet_q) - DiffW'(dry_i);
    mix_prod_d = mix_diff * $signed({1'b0, cfg_i.mix});
  end

  // Round, scale and saturate
  logic signed [FbSumW-1:0] fb_sum, fb_shift;
  logic signed [SumW-1:0]   store_sum;
  logic signed [SumW-1:0]   out_sum, out_shift;

  always_comb begin
    fb_sum    = FbSumW'(fb_prod_q) + FbSumW'(flg_pkg::GainRound);
    fb_shift  = fb_sum >>> flg_pkg::GainFracW;
    store_sum = SumW'(fb_shift) + SumW'(dry_i);
    store_val = sat_sample(store_sum);
    out_sum   = (SumW'(dry_i) <<< flg_pkg::GainFracW) + SumW'(mix_prod_q)
              + SumW'(flg_pkg::GainRound);
    out_shift = out_sum >>> flg_pkg::GainFracW;
    result_o  = sat_sample(out_shift);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_lfo) begin
      lfo_sc_q <= lfo_sc_d;
    end
    if (ctrl_i.load_sweep) begin
      delay_q <= sweep_prod[flg_pkg::SweepProdW-1:flg_pkg::SweepShift];
    end
    if (ctrl_i.load_wet) begin
      wet_q <= wet_d;
    end
    if (ctrl_i.load_prod) begin
      fb_prod_q  <= fb_prod_d;
      mix_prod_q <= mix_prod_d;
    end
  end

endmodule
